/* hdl/clu_pkg.sv */
package clu_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_LINE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_LINE_TOTAL  = 2'd1;
  localparam logic [1:0] REG_FORMAT_CODE = 2'd2;

  localparam int unsigned CFG_DATA_W = 10;

  // Reset values of the registers
  localparam logic [9:0] LINE_WIDTH_RST  = 10'd160;
  localparam logic [9:0] LINE_TOTAL_RST  = 10'd120;
  localparam logic [7:0] FORMAT_CODE_RST = 8'd0;

  // Fixed bytes of the line mark and the frame trailer
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;
  localparam logic [7:0] BYTE_FE   = 8'hFE;

  // Step counter of one output run
  localparam int unsigned STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  // Last step of each kind of run
  localparam step_t LAST_PIXEL = 5'd0;
  localparam step_t LAST_LINE  = 5'd6;
  localparam step_t LAST_FRAME = 5'd16;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_LINE,
    KIND_FRAME
  } kind_e;

  // One classified item passed from front to back
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } desc_t;

  typedef struct packed {
    logic [9:0] line_width;
    logic [9:0] line_total;
    logic [7:0] format_code;
  } cfg_t;

endpackage

/* hdl/clu_front.sv */
module clu_front import clu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] pixel_byte_i,
  input  logic       queue_full_i,
  output logic       push_o,
  output desc_t      desc_o
);

  logic [7:0]  held_q, held_d;
  logic [10:0] pos_q, pos_d;
  logic [9:0]  row_q, row_d;
  logic        accept;
  logic        line_end;
  logic        frame_end;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign push_o     = accept;

  // Classify the beat against the current line and frame
  assign line_end  = ({1'b0, pos_q} + 12'd1) >= {1'b0, cfg_i.line_width, 1'b0};
  assign frame_end = ({1'b0, row_q} + 11'd1) >= {1'b0, cfg_i.line_total};

  // The held byte is zero at the start of a line, so it is the shifted byte as is
  always_comb begin
    desc_o.data = held_q;
    if (!line_end) begin
      desc_o.kind = KIND_PIXEL;
    end else if (frame_end) begin
      desc_o.kind = KIND_FRAME;
    end else begin
      desc_o.kind = KIND_LINE;
    end
  end

  // Advance the line and frame position on each accepted beat
  always_comb begin
    held_d = held_q;
    pos_d  = pos_q;
    row_d  = row_q;
    if (accept) begin
      if (!line_end) begin
        held_d = pixel_byte_i;
        pos_d  = pos_q + 11'd1;
      end else begin
        held_d = BYTE_ZERO;
        pos_d  = '0;
        row_d  = frame_end ? '0 : row_q + 10'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pos_q  <= '0;
      row_q  <= '0;
    end else begin
      held_q <= held_d;
      pos_q  <= pos_d;
      row_q  <= row_d;
    end
  end

  a_line_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && line_end |=> pos_q == '0 && held_q == BYTE_ZERO)
    else $error("line did not restart after its last byte");

endmodule

/* hdl/clu_queue.sv */
module clu_queue import clu_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output desc_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  desc_t              mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
    ptr_next = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

endmodule

/* hdl/clu_back.sv */
module clu_back import clu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       head_valid_i,
  input  desc_t      head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);

  step_t      step_q, step_d;
  step_t      last_step;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       run_last_q;
  logic       load;
  logic       is_last;

  // Byte sent at each step of a run
  function automatic logic [7:0] run_byte(input step_t step, input logic [7:0] data,
                                          input cfg_t cfg);
    case (step)
      5'd0:              run_byte = data;
      5'd1:              run_byte = BYTE_ZERO;
      5'd2, 5'd3:        run_byte = BYTE_ONE;
      5'd4, 5'd5, 5'd6:  run_byte = BYTE_FE;
      5'd7:              run_byte = {6'd0, cfg.line_width[9:8]};
      5'd8:              run_byte = cfg.line_width[7:0];
      5'd9:              run_byte = {6'd0, cfg.line_total[9:8]};
      5'd10:             run_byte = cfg.line_total[7:0];
      5'd11:             run_byte = cfg.format_code;
      5'd12, 5'd13:      run_byte = BYTE_FE;
      default:           run_byte = BYTE_ONE;
    endcase
  endfunction

  always_comb begin
    case (head_i.kind)
      KIND_PIXEL: last_step = LAST_PIXEL;
      KIND_LINE:  last_step = LAST_LINE;
      default:    last_step = LAST_FRAME;
    endcase
  end

  // Load a new beat when the output register is empty or being drained
  assign is_last = step_q == last_step;
  assign load    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o   = load && is_last;

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      step_d      = is_last ? '0 : step_q + 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload unless a new beat is loaded
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= run_byte(step_q, head_i.data, cfg_i);
      run_last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= LAST_FRAME)
    else $error("run step beyond frame trailer");

  a_run_keeps_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != '0 |-> head_valid_i)
    else $error("queue head lost in the middle of a run");

endmodule

/* hdl/camera_line_uart_framer.sv */
// Channel   Handshake                       Payload
// pixel     pixel_valid_i / pixel_stall_o   pixel_byte_i
// out       out_valid_o / out_stall_i       out_byte_o, run_last_o
// config    cfg_we_i, cfg_index_i           cfg_data_i
//
// One pixel byte is taken per cycle while the queue is not full; each gives one output
// beat inside a line. A line end gives 7 beats and a frame end 17, one beat per cycle
// from the back sequencer while the output is not stalled, so the input stalls once the
// QUEUE_DEPTH-entry queue fills. Reset clears position, row, queue and output valid;
// registers take defaults. Output stall holds the output register; the input keeps
// flowing until the queue fills.
module camera_line_uart_framer import clu_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  pixel_valid_i,
  output logic                  pixel_stall_o,
  input  logic [7:0]            pixel_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  run_last_o
);

  cfg_t  cfg_q;
  logic  push;
  desc_t push_desc;
  logic  queue_full;
  logic  pop;
  logic  head_valid;
  desc_t head;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width  <= LINE_WIDTH_RST;
      cfg_q.line_total  <= LINE_TOTAL_RST;
      cfg_q.format_code <= FORMAT_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LINE_WIDTH:  cfg_q.line_width  <= cfg_data_i[9:0];
        REG_LINE_TOTAL:  cfg_q.line_total  <= cfg_data_i[9:0];
        REG_FORMAT_CODE: cfg_q.format_code <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  clu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (pixel_valid_i),
    .in_stall_o   (pixel_stall_o),
    .pixel_byte_i (pixel_byte_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .desc_o       (push_desc)
  );

  clu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .full_o      (queue_full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  clu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o)
  );

endmodule
